@@ sv/rtu_frame_gap_timer_top_macros.svh @@
// Assertion macros shared by the frame gap timer RTL.
`ifndef RTU_FRAME_GAP_TIMER_TOP_MACROS_SVH
`define RTU_FRAME_GAP_TIMER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define RTFGT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rtfgt assertion failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define RTFGT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rtfgt assertion failed");

`endif

@@ sv/rtfgt_pkg.sv @@
// Shared types, codes and helpers of the frame gap timer.
package rtfgt_pkg;

    localparam int TICK_COUNT_BITS = 16;
    localparam int MAX_FRAME_BYTES = 256;
    localparam int LEN_W           = $clog2(MAX_FRAME_BYTES + 1);
    localparam int CFG_W           = 16;
    localparam int CFG_IDX_W       = 2;
    localparam int QDEPTH          = 3;
    localparam int QPTR_W          = $clog2(QDEPTH);
    localparam int QCNT_W          = $clog2(QDEPTH + 1);

    typedef logic [TICK_COUNT_BITS-1:0] cnt_t;
    typedef logic [LEN_W-1:0]           blen_t;

    localparam cnt_t CNT_MAX = '1;

    typedef enum logic [1:0] {
        REQ_TICK    = 2'd0,
        REQ_BYTE    = 2'd1,
        REQ_TXDONE  = 2'd2,
        REQ_TIMEOUT = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        KIND_DATA    = 2'd0,
        KIND_END     = 2'd1,
        KIND_IDLE    = 2'd2,
        KIND_TIMEOUT = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHAR_GAP  = 2'd0,
        REG_FRAME_GAP = 2'd1,
        REG_MAX_LEN   = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] char_gap;
        logic [15:0] frame_gap;
        logic [8:0]  max_len;
    } cfg_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
        logic        bad;
        logic [8:0]  len;
        logic        last;
    } res_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
    } q_status_t;

    // Zero acts as one, anything above the counter range as its maximum.
    function automatic cnt_t eff_thresh(logic [15:0] t);
        logic [32:0] tw;
        tw = 33'(t);
        if (tw == 33'd0)
        begin
            tw = 33'd1;
        end
        if (tw > 33'(CNT_MAX))
        begin
            tw = 33'(CNT_MAX);
        end
        return cnt_t'(tw);
    endfunction

    function automatic blen_t frame_limit(logic [8:0] m);
        if (32'(m) > MAX_FRAME_BYTES)
        begin
            return blen_t'(MAX_FRAME_BYTES);
        end
        return blen_t'(m);
    endfunction

endpackage

@@ sv/rtfgt_core.sv @@
// Input register, line state and single-pass result logic.
`include "rtu_frame_gap_timer_top_macros.svh"

module rtfgt_core
    import rtfgt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       beat_in,
    input  logic [1:0] req_in,
    input  logic [7:0] byte_in,
    input  cfg_t       cfg,
    output logic       in_flight,
    output logic       res_valid,
    output res_t       res
);

    typedef enum logic [2:0] {
        M_STARTUP,
        M_IDLE,
        M_FRAME,
        M_GAP,
        M_TURN
    } mode_t;

    mode_t      mode_reg, mode_next;
    cnt_t       sc_reg, sc_next;
    blen_t      bc_reg, bc_next;
    logic       err_reg, err_next;
    logic       valid_reg;
    req_t       req_reg;
    logic [7:0] byte_reg;

    cnt_t  sc_inc;
    cnt_t  thr_char;
    cnt_t  thr_frame;
    blen_t limit;
    blen_t bc_base;
    mode_t gap_mode;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_STARTUP;
            sc_reg    <= '0;
            bc_reg    <= '0;
            err_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            sc_reg    <= sc_next;
            bc_reg    <= bc_next;
            err_reg   <= err_next;
            valid_reg <= beat_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (beat_in)
        begin
            req_reg  <= req_t'(req_in);
            byte_reg <= byte_in;
        end
    end

    assign sc_inc    = (sc_reg == CNT_MAX) ? sc_reg : sc_reg + cnt_t'(1);
    assign thr_char  = eff_thresh(cfg.char_gap);
    assign thr_frame = eff_thresh(cfg.frame_gap);
    assign limit     = frame_limit(cfg.max_len);
    assign bc_base   = (mode_reg == M_IDLE) ? '0 : bc_reg;
    assign gap_mode  = (mode_reg == M_FRAME && sc_inc >= thr_char) ? M_GAP : mode_reg;
    assign in_flight = valid_reg;

    always_comb
    begin
        mode_next = mode_reg;
        sc_next   = sc_reg;
        bc_next   = bc_reg;
        err_next  = err_reg;
        res_valid = 1'b0;
        res       = '{kind: KIND_DATA, data: 8'd0, bad: 1'b0, len: 9'd0, last: 1'b0};
        if (valid_reg)
        begin
            case (req_reg)
                REQ_TICK:
                begin
                    if (mode_reg != M_IDLE)
                    begin
                        sc_next = sc_inc;
                        if (mode_reg == M_STARTUP || mode_reg == M_TURN)
                        begin
                            if (sc_inc >= thr_frame)
                            begin
                                mode_next = M_IDLE;
                                sc_next   = '0;
                                res_valid = 1'b1;
                                res.kind  = KIND_IDLE;
                            end
                        end
                        else
                        begin
                            mode_next = gap_mode;
                            if (gap_mode == M_GAP && sc_inc >= thr_frame)
                            begin
                                res_valid = 1'b1;
                                res.kind  = KIND_END;
                                res.bad   = err_reg;
                                res.len   = 9'(bc_reg);
                                res.last  = 1'b1;
                                mode_next = M_IDLE;
                                sc_next   = '0;
                                bc_next   = '0;
                                err_next  = 1'b0;
                            end
                        end
                    end
                end
                REQ_BYTE:
                begin
                    unique case (mode_reg) inside
                        M_STARTUP:
                        begin
                            sc_next = '0;
                        end
                        M_IDLE, M_FRAME:
                        begin
                            mode_next = M_FRAME;
                            sc_next   = '0;
                            bc_next   = bc_base;
                            if (mode_reg == M_IDLE)
                            begin
                                err_next = 1'b0;
                            end
                            if (bc_base < limit)
                            begin
                                bc_next   = bc_base + blen_t'(1);
                                res_valid = 1'b1;
                                res.kind  = KIND_DATA;
                                res.data  = byte_reg;
                            end
                        end
                        M_GAP:
                        begin
                            err_next = 1'b1;
                        end
                        default:
                        begin
                            // turnaround: byte ignored
                        end
                    endcase
                end
                REQ_TXDONE:
                begin
                    mode_next = M_TURN;
                    sc_next   = '0;
                    bc_next   = '0;
                    err_next  = 1'b0;
                end
                default:
                begin
                    if (mode_reg == M_IDLE)
                    begin
                        res_valid = 1'b1;
                        res.kind  = KIND_TIMEOUT;
                    end
                end
            endcase
        end
    end

    `RTFGT_ASSERT_IMPL(a_idle_count_clear, mode_reg == M_IDLE, sc_reg == '0)
    `RTFGT_ASSERT_IMPL(a_len_in_range, 1'b1, 32'(bc_reg) <= MAX_FRAME_BYTES)
    `RTFGT_ASSERT_NEXT(a_end_goes_idle, res_valid && res.kind == KIND_END,
                       mode_reg == M_IDLE && bc_reg == '0)

endmodule

@@ sv/rtfgt_outq.sv @@
// Three-entry result queue feeding the output channel.
`include "rtu_frame_gap_timer_top_macros.svh"

module rtfgt_outq
    import rtfgt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  res_t      push_res,
    input  logic      pop,
    output logic      head_valid,
    output res_t      head_res,
    output q_status_t status
);

    res_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(logic [QPTR_W-1:0] p);
        return (32'(p) == QDEPTH - 1) ? '0 : p + QPTR_W'(1);
    endfunction

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_res;
        end
    end

    assign head_valid   = (count_reg != '0);
    assign head_res     = mem_reg[rd_ptr_reg];
    assign status.count = count_reg;

    `RTFGT_ASSERT_IMPL(a_no_push_full, push, 32'(count_reg) < QDEPTH)
    `RTFGT_ASSERT_IMPL(a_pop_has_data, pop, count_reg != '0)
    `RTFGT_ASSERT_NEXT(a_drain_last, pop && !push && count_reg == QCNT_W'(1), !head_valid)

endmodule

@@ sv/rtu_frame_gap_timer_top.sv @@
// Top level of the serial frame gap timer: config registers and channel glue.
//
// Serial frame gap timer. Each input beat is one event: a timer tick, a
// received byte (rx_byte), a transmit-done or a response timeout. The
// block counts ticks of line silence to split the byte stream into frames:
// after reset it waits frame_gap_ticks (t3.5) of silence before reporting
// the line idle; the first byte on an idle line opens a frame, every byte
// kept is forwarded as a data beat and restarts the count; char_gap_ticks
// (t1.5) of silence closes the frame and frame_gap_ticks of silence emits a
// frame end beat carrying the length and a bad flag (set when bytes arrived
// between t1.5 and t3.5; those bytes are dropped). Bytes beyond
// max_frame_len are dropped. Transmit-done abandons any frame and starts a
// t3.5 turnaround wait ending in a line idle beat. Each event gives zero or
// one result beat.
// Timing: one event per clock is accepted while in_stall is low. An event
// is registered on entry and its result lands in a three-entry output
// queue on the next edge. in_stall rises only when the queue together
// with the event in flight would fill it, i.e. when the output side has
// stalled for a while. Configuration must be written by the user through
// cfg_we/cfg_index/cfg_data only while the block is idle; the block does
// not enforce it. Index 0 char_gap_ticks, 1 frame_gap_ticks, 2 max_frame_len.
module rtu_frame_gap_timer_top
    import rtfgt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           req_type,
    input  logic [7:0]           rx_byte,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           result_kind,
    output logic [7:0]           data_byte,
    output logic                 frame_bad,
    output logic [8:0]           frame_len,
    output logic                 frame_last,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    cfg_t      cfg_reg;
    logic      beat_in;
    logic      in_flight;
    logic      res_valid;
    res_t      res;
    res_t      head_res;
    q_status_t q_status;
    logic      pop;

    // Config registers; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.char_gap  <= 16'd15;
            cfg_reg.frame_gap <= 16'd35;
            cfg_reg.max_len   <= 9'd256;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CHAR_GAP:  cfg_reg.char_gap  <= cfg_data;
                REG_FRAME_GAP: cfg_reg.frame_gap <= cfg_data;
                REG_MAX_LEN:   cfg_reg.max_len   <= cfg_data[8:0];
                default:       ;
            endcase
        end
    end

    // Reserve a queue slot for the event already in the input register.
    assign in_stall = (32'(q_status.count) + 32'(in_flight)) >= QDEPTH;
    assign beat_in  = in_valid && !in_stall;
    assign pop      = out_valid && !out_stall;

    rtfgt_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .beat_in   (beat_in),
        .req_in    (req_type),
        .byte_in   (rx_byte),
        .cfg       (cfg_reg),
        .in_flight (in_flight),
        .res_valid (res_valid),
        .res       (res)
    );

    rtfgt_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (res_valid),
        .push_res   (res),
        .pop        (pop),
        .head_valid (out_valid),
        .head_res   (head_res),
        .status     (q_status)
    );

    assign result_kind = head_res.kind;
    assign data_byte   = head_res.data;
    assign frame_bad   = head_res.bad;
    assign frame_len   = head_res.len;
    assign frame_last  = head_res.last;

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the serial frame gap timer, rtu_frame_gap_timer_top.
`timescale 1ns / 100ps

module tb;
    import rtfgt_pkg::*;

    // Generous bound on the whole run, several times the worst stalled case.
    localparam int LIMIT_CYCLES = 200000;

    // Line states of the predictor, kept apart from the RTL's own encoding
    typedef enum logic [2:0] {
        LM_STARTUP,
        LM_IDLE,
        LM_FRAME,
        LM_GAP,
        LM_TURN
    } line_mode_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [1:0]           req_type;
    logic [7:0]           rx_byte;
    logic                 out_valid;
    logic                 out_stall;
    logic [1:0]           result_kind;
    logic [7:0]           data_byte;
    logic                 frame_bad;
    logic [8:0]           frame_len;
    logic                 frame_last;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    // Predictor: register copies and line state
    logic [15:0] cfg_char_gap  = 16'd15;
    logic [15:0] cfg_frame_gap = 16'd35;
    logic [8:0]  cfg_max_len   = 9'd256;
    line_mode_t  mdl_mode      = LM_STARTUP;
    logic [15:0] mdl_silence   = '0;
    logic [8:0]  mdl_bytes     = '0;
    logic        mdl_gap_err   = 1'b0;

    res_t expected_beats[$];

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    int  hold_cycles    = 0;
    bit  sender_idles   = 1'b1;
    bit  stall_idles    = 1'b1;
    int  frame_sent     = 0;
    int  frame_target   = 0;

    rtu_frame_gap_timer_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_kind (result_kind),
        .data_byte   (data_byte),
        .frame_bad   (frame_bad),
        .frame_len   (frame_len),
        .frame_last  (frame_last),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // A zero threshold behaves as one; 16-bit values never exceed the counter.
    function automatic logic [15:0] gap_limit(input logic [15:0] t);
        return (t == 16'd0) ? 16'd1 : t;
    endfunction

    // Bytes kept per frame, clipped to the block's storage size
    function automatic logic [8:0] frame_cap();
        return (cfg_max_len > 9'd256) ? 9'd256 : cfg_max_len;
    endfunction

    // Advances the line state by one event; returns 1 with the beat it causes.
    function automatic bit predict_line_event(input req_t r, input logic [7:0] b,
                                              output res_t o);
        o.kind = KIND_DATA;
        o.data = '0;
        o.bad  = 1'b0;
        o.len  = '0;
        o.last = 1'b0;
        case (r)
            REQ_TICK:
            begin
                if (mdl_mode == LM_IDLE)
                begin
                    return 1'b0;
                end
                if (mdl_silence != 16'hFFFF)
                begin
                    mdl_silence = mdl_silence + 16'd1;
                end
                if (mdl_mode == LM_STARTUP || mdl_mode == LM_TURN)
                begin
                    if (mdl_silence >= gap_limit(cfg_frame_gap))
                    begin
                        mdl_mode    = LM_IDLE;
                        mdl_silence = '0;
                        o.kind      = KIND_IDLE;
                        return 1'b1;
                    end
                    return 1'b0;
                end
                // t1.5 and t3.5 can fall on the same tick when the gaps are inverted
                if (mdl_mode == LM_FRAME && mdl_silence >= gap_limit(cfg_char_gap))
                begin
                    mdl_mode = LM_GAP;
                end
                if (mdl_mode == LM_GAP && mdl_silence >= gap_limit(cfg_frame_gap))
                begin
                    o.kind      = KIND_END;
                    o.bad       = mdl_gap_err;
                    o.len       = mdl_bytes;
                    o.last      = 1'b1;
                    mdl_mode    = LM_IDLE;
                    mdl_silence = '0;
                    mdl_bytes   = '0;
                    mdl_gap_err = 1'b0;
                    return 1'b1;
                end
                return 1'b0;
            end
            REQ_BYTE:
            begin
                case (mdl_mode)
                    LM_STARTUP:
                    begin
                        mdl_silence = '0;
                    end
                    LM_IDLE, LM_FRAME:
                    begin
                        if (mdl_mode == LM_IDLE)
                        begin
                            mdl_mode    = LM_FRAME;
                            mdl_bytes   = '0;
                            mdl_gap_err = 1'b0;
                        end
                        mdl_silence = '0;
                        if (mdl_bytes < frame_cap())
                        begin
                            mdl_bytes = mdl_bytes + 9'd1;
                            o.kind    = KIND_DATA;
                            o.data    = b;
                            return 1'b1;
                        end
                    end
                    LM_GAP:
                    begin
                        mdl_gap_err = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
                return 1'b0;
            end
            REQ_TXDONE:
            begin
                mdl_mode    = LM_TURN;
                mdl_silence = '0;
                mdl_bytes   = '0;
                mdl_gap_err = 1'b0;
                return 1'b0;
            end
            default:
            begin
                if (mdl_mode == LM_IDLE)
                begin
                    o.kind = KIND_TIMEOUT;
                    return 1'b1;
                end
                return 1'b0;
            end
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Result checking, sampled at the rising edge
    // ---------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 40)
        begin
            $display("MISMATCH cycle %0d: %s", cycle_count, msg);
        end
    endtask

    always @(posedge clk)
    begin : check_beats
        res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_beats.size() == 0)
            begin
                report_mismatch($sformatf("unexpected beat kind %0d", result_kind));
            end
            else
            begin
                want = expected_beats.pop_front();
                if (result_kind != want.kind)
                begin
                    report_mismatch($sformatf("result_kind %0d, want %0d",
                                              result_kind, want.kind));
                end
                if (data_byte != want.data)
                begin
                    report_mismatch($sformatf("data_byte %0h, want %0h", data_byte, want.data));
                end
                if (frame_bad != want.bad)
                begin
                    report_mismatch($sformatf("frame_bad %0d, want %0d", frame_bad, want.bad));
                end
                if (frame_len != want.len)
                begin
                    report_mismatch($sformatf("frame_len %0d, want %0d", frame_len, want.len));
                end
                if (frame_last != want.last)
                begin
                    report_mismatch($sformatf("frame_last %0d, want %0d",
                                              frame_last, want.last));
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Receiver stall: random bursts, or one long counted hold-off on request
    // ---------------------------------------------------------------
    initial
    begin : sink_stall
        int n;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                n = hold_cycles;
                hold_cycles = 0;
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
                out_stall <= 1'b0;
            end
            else if (stall_idles && $urandom_range(0, 9) == 0)
            begin
                n = $urandom_range(1, 16);
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Shared stimulus tasks; all entered and left at a falling edge
    // ---------------------------------------------------------------

    // Offers one event beat, holds it until taken, then predicts its result.
    task automatic send_event(input req_t r, input logic [7:0] b);
        int   gap;
        res_t beat;
        if (sender_idles && $urandom_range(0, 9) == 0)
        begin
            gap = $urandom_range(1, 16);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= r;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        if (predict_line_event(r, b, beat))
        begin
            expected_beats.push_back(beat);
        end
        @(negedge clk);
    endtask

    // Sender goes quiet until every predicted beat is out, plus the
    // pipeline depth for events that give no beat.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_beats.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (6) @(negedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [15:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_CHAR_GAP:  cfg_char_gap  = v;
            REG_FRAME_GAP: cfg_frame_gap = v;
            default:       cfg_max_len   = v[8:0];
        endcase
    endtask

    task automatic set_timing(input logic [15:0] cg, input logic [15:0] fg,
                              input logic [15:0] ml);
        drain_results();
        write_reg(REG_CHAR_GAP, cg);
        write_reg(REG_FRAME_GAP, fg);
        write_reg(REG_MAX_LEN, ml);
    endtask

    task automatic tick_until_idle();
        while (mdl_mode != LM_IDLE)
        begin
            send_event(REQ_TICK, 8'($urandom));
        end
    endtask

    // n random bytes back to back, then silence until the frame end
    task automatic send_frame(input int n);
        for (int i = 0; i < n; i++)
        begin
            send_event(REQ_BYTE, 8'($urandom));
        end
        tick_until_idle();
    endtask

    // Mostly well-formed traffic steered by the predicted line state:
    // frames of random length, short inter-byte gaps, a few late bytes,
    // turnarounds and timeouts. Events the block just ignores are not counted.
    task automatic run_random(input int n_items);
        int   done;
        int   pick;
        int   hi;
        req_t r;
        bit   ignored;
        done = 0;
        while (done < n_items)
        begin
            pick = $urandom_range(0, 99);
            case (mdl_mode)
                LM_IDLE:
                begin
                    if (pick < 75)      r = REQ_BYTE;
                    else if (pick < 87) r = REQ_TIMEOUT;
                    else if (pick < 93) r = REQ_TXDONE;
                    else                r = REQ_TICK;
                end
                LM_FRAME:
                begin
                    if (pick < 2)
                        r = REQ_TXDONE;
                    else if (pick < 3)
                        r = REQ_TIMEOUT;
                    else if (frame_sent < frame_target &&
                             (mdl_silence >= gap_limit(cfg_char_gap) - 16'd1 || pick < 58))
                        r = REQ_BYTE;
                    else
                        r = REQ_TICK;
                end
                LM_GAP:
                begin
                    if (pick < 80)      r = REQ_TICK;
                    else if (pick < 95) r = REQ_BYTE;
                    else if (pick < 98) r = REQ_TIMEOUT;
                    else                r = REQ_TXDONE;
                end
                default:
                begin
                    if (pick < 88)      r = REQ_TICK;
                    else if (pick < 94) r = REQ_BYTE;
                    else if (pick < 97) r = REQ_TIMEOUT;
                    else                r = REQ_TXDONE;
                end
            endcase
            ignored = (r == REQ_TICK && mdl_mode == LM_IDLE) ||
                      (r == REQ_TIMEOUT && mdl_mode != LM_IDLE) ||
                      (r == REQ_BYTE && mdl_mode == LM_TURN);
            if (r == REQ_BYTE && mdl_mode == LM_IDLE)
            begin
                // new frame: mostly short, sometimes up to just past the limit, at most 40 bytes
                hi = int'(frame_cap()) + 2;
                if (hi > 40)
                begin
                    hi = 40;
                end
                frame_sent   = 0;
                frame_target = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8)
                                                          : $urandom_range(1, hi);
            end
            if (r == REQ_BYTE)
            begin
                frame_sent++;
            end
            send_event(r, 8'($urandom));
            if (!ignored)
            begin
                done++;
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Short gaps first, then a byte in the startup wait restarts it.
    task automatic test_startup();
        set_timing(16'd2, 16'd3, 16'd256);
        send_event(REQ_TICK, 8'h00);
        send_event(REQ_TICK, 8'hFF);
        send_event(REQ_BYTE, 8'hC3);
        send_event(REQ_TIMEOUT, 8'h00);
        tick_until_idle();
    endtask

    // Each event type, data extremes, late byte, abandon.
    task automatic test_basic_events();
        send_event(REQ_TIMEOUT, 8'h00);
        send_event(REQ_TICK, 8'h00);
        send_event(REQ_BYTE, 8'h00);
        send_event(REQ_BYTE, 8'hFF);
        send_event(REQ_TICK, 8'h00);
        send_event(REQ_TICK, 8'h00);
        send_event(REQ_BYTE, 8'hA5);   // after t1.5: dropped, frame marked bad
        send_event(REQ_TICK, 8'h00);
        send_event(REQ_BYTE, 8'h5A);
        send_event(REQ_TICK, 8'h00);
        send_event(REQ_BYTE, 8'h81);
        send_event(REQ_TXDONE, 8'h00); // frame abandoned, no end beat
        send_event(REQ_BYTE, 8'h33);   // ignored in turnaround
        send_event(REQ_TIMEOUT, 8'h00);
        tick_until_idle();
    endtask

    // t1.5 not below t3.5, and zero thresholds behaving as one tick
    task automatic test_gap_order();
        set_timing(16'd5, 16'd3, 16'd256);
        send_frame(2);
        set_timing(16'd0, 16'd0, 16'd256);
        send_frame(1);
        send_event(REQ_TICK, 8'h00);
        send_event(REQ_TXDONE, 8'h00);
        tick_until_idle();
    endtask

    // Length limit: one byte, zero bytes, above the storage size, and the full size
    task automatic test_frame_limit();
        set_timing(16'd1, 16'd2, 16'd1);
        send_frame(3);
        set_timing(16'd1, 16'd2, 16'd0);
        send_frame(2);
        set_timing(16'd1, 16'd2, 16'd511);
        send_frame(258);
        set_timing(16'd1, 16'd2, 16'd256);
        send_frame(3);
    endtask

    // Receiver holds off long enough for the block to fill and stall its input.
    task automatic test_output_hold();
        set_timing(16'd2, 16'd4, 16'd256);
        hold_cycles = 120;
        send_frame(40);
    endtask

    // Widest gaps: a turnaround and a frame that never time out at full scale,
    // then short gaps let the waits end.
    task automatic test_widest_gap();
        set_timing(16'hFFFF, 16'hFFFF, 16'd256);
        send_event(REQ_TXDONE, 8'h00);
        repeat (20) send_event(REQ_TICK, 8'h00);
        set_timing(16'd1, 16'd1, 16'd256);
        tick_until_idle();
        set_timing(16'hFFFF, 16'hFFFF, 16'd256);
        send_event(REQ_BYTE, 8'h11);
        send_event(REQ_BYTE, 8'hEE);
        repeat (20) send_event(REQ_TICK, 8'h00);
        send_event(REQ_TXDONE, 8'h00);
        set_timing(16'd1, 16'd1, 16'd256);
        tick_until_idle();
    endtask

    // Several register settings with random traffic under each
    task automatic test_random_traffic();
        logic [15:0] cg;
        logic [15:0] fg;
        logic [15:0] ml;
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:
                begin
                    cg = 16'($urandom_range(1, 4));
                    fg = 16'($urandom_range(1, 8));
                    ml = 16'($urandom_range(1, 6));
                end
                1:
                begin
                    cg = 16'd15;
                    fg = 16'd35;
                    ml = 16'd256;
                end
                2:
                begin
                    fg = 16'($urandom_range(1, 4));
                    cg = fg + 16'($urandom_range(0, 3));
                    ml = 16'($urandom_range(1, 256));
                end
                3:
                begin
                    cg = 16'd1;
                    fg = 16'd1;
                    ml = 16'd256;
                end
                4:
                begin
                    cg = 16'($urandom_range(1, 3));
                    fg = 16'($urandom_range(2, 6));
                    ml = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 3))
                                                     : 16'($urandom_range(300, 511));
                end
                default:
                begin
                    cg = 16'($urandom_range(1, 8));
                    fg = 16'($urandom_range(1, 12));
                    ml = 16'($urandom_range(1, 511));
                end
            endcase
            set_timing(cg, fg, ml);
            run_random(100);
        end
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        req_type  = REQ_TICK;
        rx_byte   = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_CHAR_GAP;
        cfg_data  = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_startup();
        test_basic_events();
        test_gap_order();
        test_frame_limit();
        test_output_hold();
        test_widest_gap();
        test_random_traffic();

        // Closing stretch at full rate on both sides
        set_timing(16'd3, 16'd6, 16'd12);
        sender_idles = 1'b0;
        stall_idles  = 1'b0;
        run_random(100);

        drain_results();
        repeat (10) @(negedge clk);
        if (mismatch_count == 0 && expected_beats.size() == 0)
        begin
            $display("tb: clean");
        end
        else
        begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/rtfgt_pkg.sv
sv/rtfgt_core.sv
sv/rtfgt_outq.sv
sv/rtu_frame_gap_timer_top.sv
tb/tb.sv
